@@ sv/efq_pkg.sv @@
// Shared constants, types and a helper function for the expiring FIFO queue.
package efq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NOP  = 2'd3
  } efq_mode_e;

  typedef struct packed {
    logic [DATA_W-1:0] patience;
    logic [DATA_W-1:0] service;
  } efq_entry_t;

  typedef struct packed {
    logic                 out_valid;
    logic [DATA_W-1:0]    patience_out;
    logic [DATA_W-1:0]    service_out;
    logic [OUT_CNT_W-1:0] expired_count;
    logic [OUT_CNT_W-1:0] occupancy;
    logic                 is_empty;
    logic                 overflow;
  } efq_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic walk;
    logic load_out;
  } efq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
  } efq_sts_t;

  // Circular pointer increment that wraps at the queue depth.
  function automatic logic [PTR_W-1:0] efq_next(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

@@ sv/efq_if.sv @@
// Valid/ready channel interfaces for the queue's operation and result transactions.
interface efq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] patience_in;
  logic [7:0] service_in;

  modport source (output valid, output mode, output patience_in, output service_in,
                  input ready);
  modport sink (input valid, input mode, input patience_in, input service_in,
                output ready);
endinterface

interface efq_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] patience_out;
  logic [7:0] service_out;
  logic [4:0] expired_count;
  logic [4:0] occupancy;
  logic       is_empty;
  logic       overflow;

  modport source (output valid, output out_valid, output patience_out,
                  output service_out, output expired_count, output occupancy,
                  output is_empty, output overflow, input ready);
  modport sink (input valid, input out_valid, input patience_out, input service_out,
                input expired_count, input occupancy, input is_empty, input overflow,
                output ready);
endinterface

@@ sv/efq_ctrl.sv @@
// Sequencing state machine for the expiring FIFO queue.
module efq_ctrl import efq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] in_mode_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  efq_sts_t sts_i,
  output efq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.walk     = (state_q == ST_WALK);
    cmd_o.load_out = (state_q == ST_FINISH) && slot_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (efq_mode_e'(in_mode_i) == MODE_TICK) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A finished result is never dropped: the output slot fills on the cycle after loading.
  a_load_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("efq_ctrl: loaded result did not appear on the output");
`endif

endmodule

@@ sv/efq_dpath.sv @@
// Entry memory, pointers, compaction walk and result register of the queue.
module efq_dpath import efq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  efq_cmd_t    cmd_i,
  output efq_sts_t    sts_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  patience_i,
  input  logic [7:0]  service_i,
  output efq_res_t    res_o
);

  efq_entry_t mem_q [DEPTH];
  efq_entry_t rd_data_q;

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issued_q, issued_d, kept_q, kept_d, expired_q, expired_d;
  logic             pend_q, pend_d;
  logic             res_valid_q, res_valid_d;
  logic             ovf_q, ovf_d;
  efq_res_t         out_q, out_d;

  logic             we, re;
  logic [PTR_W-1:0] waddr, raddr;
  efq_entry_t       wdata;
  logic             full, issue, walk_done;

  assign full      = (count_q == CNT_W'(DEPTH));
  assign issue     = (issued_q != count_q);
  assign walk_done = !issue && !pend_q;
  assign sts_o.walk_done = walk_done;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    issued_d    = issued_q;
    kept_d      = kept_q;
    expired_d   = expired_q;
    pend_d      = pend_q;
    res_valid_d = res_valid_q;
    ovf_d       = ovf_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = tail_q;
    raddr       = head_q;
    wdata       = '{patience: patience_i, service: service_i};

    if (cmd_i.start) begin
      expired_d   = '0;
      res_valid_d = 1'b0;
      ovf_d       = 1'b0;
      unique case (efq_mode_e'(mode_i))
        MODE_ENQ: begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            we      = 1'b1;
            tail_d  = efq_next(tail_q);
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_DEQ: begin
          if (count_q != '0) begin
            re          = 1'b1;
            res_valid_d = 1'b1;
            head_d      = efq_next(head_q);
            count_d     = count_q - CNT_W'(1);
          end
        end
        MODE_TICK: begin
          rd_ptr_d = head_q;
          wr_ptr_d = head_q;
          issued_d = '0;
          kept_d   = '0;
          pend_d   = 1'b0;
        end
        MODE_NOP: begin
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.walk) begin
      // Read the next entry while the previous one is aged and written back behind it.
      pend_d = issue;
      if (issue) begin
        re       = 1'b1;
        raddr    = rd_ptr_q;
        rd_ptr_d = efq_next(rd_ptr_q);
        issued_d = issued_q + CNT_W'(1);
      end
      if (pend_q) begin
        if (rd_data_q.patience <= DATA_W'(1)) begin
          expired_d = expired_q + CNT_W'(1);
        end else begin
          we       = 1'b1;
          waddr    = wr_ptr_q;
          wdata    = '{patience: rd_data_q.patience - DATA_W'(1),
                       service:  rd_data_q.service};
          wr_ptr_d = efq_next(wr_ptr_q);
          kept_d   = kept_q + CNT_W'(1);
        end
      end
      if (walk_done) begin
        tail_d  = wr_ptr_q;
        count_d = kept_q;
      end
    end
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.load_out) begin
      out_d.out_valid     = res_valid_q;
      out_d.patience_out  = res_valid_q ? rd_data_q.patience : '0;
      out_d.service_out   = res_valid_q ? rd_data_q.service : '0;
      out_d.expired_count = OUT_CNT_W'(expired_q);
      out_d.occupancy     = OUT_CNT_W'(count_q);
      out_d.is_empty      = (count_q == '0);
      out_d.overflow      = ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem_q[raddr];
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      issued_q    <= '0;
      kept_q      <= '0;
      expired_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      issued_q    <= issued_d;
      kept_q      <= kept_d;
      expired_q   <= expired_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      ovf_q       <= ovf_d;
    end
  end

  assign res_o = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("efq_dpath: entry count above queue depth");

  a_walk_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> ({1'b0, kept_q} + {1'b0, expired_q}) <= {1'b0, issued_q})
    else $error("efq_dpath: walk retired more entries than it read");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && efq_mode_e'(mode_i) == MODE_ENQ && !full)
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("efq_dpath: accepted enqueue did not add an entry");

  a_walk_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk && walk_done) |=> count_q <= $past(count_q))
    else $error("efq_dpath: compaction grew the queue");
`endif

endmodule

@@ sv/expiring_fifo_queue.sv @@
// Top level of the expiring FIFO queue: controller and datapath joined by commands and status.
//
//   Channel  Direction  Transaction carries
//   in_i     sink       mode, patience_in, service_in (enqueue, dequeue or tick)
//   out_o    source     out_valid, patience_out, service_out, expired_count,
//                       occupancy, is_empty, overflow
//
// An enqueue, a dequeue or an idle mode loads its result straight after acceptance,
// once the output slot is free. A tick reads its entries one by one through the single
// read port, ages the last entry read, closes the walk and then loads its result; a tick
// on an empty queue closes its walk at once. After reset the queue is empty and an
// operation can be accepted at once. Input is accepted whenever the sequencer is idle,
// even while an earlier result waits on the output; a stalled output holds the
// finished result of the next operation in the sequencer until the output slot frees.
module expiring_fifo_queue import efq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  efq_in_if.sink    in_i,
  efq_out_if.source out_o
);

  efq_cmd_t cmd;
  efq_sts_t sts;
  efq_res_t res;

  // The controller sequences each transaction: it accepts one operation, runs the
  // tick walk when needed and hands the result to the output register.
  efq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the circular entry memory, its head and tail pointers, the
  // entry count and the registered result.
  efq_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .mode_i     (in_i.mode),
    .patience_i (in_i.patience_in),
    .service_i  (in_i.service_in),
    .res_o      (res)
  );

  assign out_o.out_valid     = res.out_valid;
  assign out_o.patience_out  = res.patience_out;
  assign out_o.service_out   = res.service_out;
  assign out_o.expired_count = res.expired_count;
  assign out_o.occupancy     = res.occupancy;
  assign out_o.is_empty      = res.is_empty;
  assign out_o.overflow      = res.overflow;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the expiring FIFO queue: directed and random operations.
module testbench import efq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Length of the one long output stall that makes the queue back up and refuse
  // input. It is counted in clock cycles by the result receiver.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Random operations after the directed opening.
  localparam int unsigned RANDOM_OPS = 1150;
  // The final stretch of operations is run with no idling on either side.
  localparam int unsigned STEADY_TAIL_OPS = 150;
  // A tick walks every entry of the queue, so this covers the longest
  // operation with room to spare when waiting for stray results at the end.
  localparam int unsigned DRAIN_CYCLES = DEPTH + 16;

  // The scoreboard keeps its own image of the queue contents. Every accepted
  // operation is applied to that image straight away and the result it must
  // produce is queued. Each result transaction from the block is then compared
  // field by field with the oldest queued result.
  class efq_scoreboard;
    efq_entry_t  held_entries[$];
    efq_res_t    awaited_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void accept_operation(efq_mode_e op, logic [DATA_W-1:0] patience,
                                   logic [DATA_W-1:0] service);
      efq_res_t    res;
      efq_entry_t  ent;
      efq_entry_t  survivors[$];
      int unsigned expired;
      res     = '0;
      expired = 0;
      case (op)
        MODE_ENQ: begin
          // A full queue refuses the entry and flags overflow instead.
          if (held_entries.size() >= DEPTH) begin
            res.overflow = 1'b1;
          end else begin
            ent.patience = patience;
            ent.service  = service;
            held_entries.push_back(ent);
          end
        end
        MODE_DEQ: begin
          // An empty queue gives a result that is not valid, with zero data.
          if (held_entries.size() > 0) begin
            ent              = held_entries.pop_front();
            res.out_valid    = 1'b1;
            res.patience_out = ent.patience;
            res.service_out  = ent.service;
          end
        end
        MODE_TICK: begin
          // Patience of one or zero runs out on this tick; the rest age by one
          // and close up behind each other in their original order.
          foreach (held_entries[i]) begin
            if (held_entries[i].patience <= 1) begin
              expired++;
            end else begin
              ent          = held_entries[i];
              ent.patience = ent.patience - 1'b1;
              survivors.push_back(ent);
            end
          end
          held_entries      = survivors;
          res.expired_count = OUT_CNT_W'(expired);
        end
        default: begin
          // The unused mode changes nothing and just reports the status.
        end
      endcase
      res.occupancy = OUT_CNT_W'(held_entries.size());
      res.is_empty  = (held_entries.size() == 0);
      awaited_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(efq_res_t got);
      efq_res_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("out_valid",     want.out_valid,     got.out_valid);
        compare_field("patience_out",  want.patience_out,  got.patience_out);
        compare_field("service_out",   want.service_out,   got.service_out);
        compare_field("expired_count", want.expired_count, got.expired_count);
        compare_field("occupancy",     want.occupancy,     got.occupancy);
        compare_field("is_empty",      want.is_empty,      got.is_empty);
        compare_field("overflow",      want.overflow,      got.overflow);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  efq_in_if  in_if();
  efq_out_if out_if();

  efq_scoreboard sb;

  // Set by the stimulus once the random part starts; the receiver answers it
  // with one long stall, once only.
  logic hold_off_req;
  // Set for the last stretch of the run, where neither side idles.
  logic steady_tail;

  expiring_fifo_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Offers one operation and waits until the block takes it. The task is
  // entered at a falling edge and returns at the falling edge after the
  // transaction, so a following call keeps valid high without a glitch.
  // Before the offer there may be a random burst of idle cycles.
  task automatic send_op(efq_mode_e op, logic [DATA_W-1:0] patience,
                         logic [DATA_W-1:0] service);
    int unsigned gap;
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid       <= 1'b0;
      in_if.mode        <= MODE_NOP;
      in_if.patience_in <= DATA_W'($urandom_range(0, 255));
      in_if.service_in  <= DATA_W'($urandom_range(0, 255));
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= op;
    in_if.patience_in <= patience;
    in_if.service_in  <= service;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    sb.accept_operation(op, patience, service);
    @(negedge clk_i);
  endtask

  // Every result transaction goes to the scoreboard. Outputs are sampled at
  // the rising edge, before the block's own updates of that edge take effect.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result('{out_valid:     out_if.out_valid,
                        patience_out:  out_if.patience_out,
                        service_out:   out_if.service_out,
                        expired_count: out_if.expired_count,
                        occupancy:     out_if.occupancy,
                        is_empty:      out_if.is_empty,
                        overflow:      out_if.overflow});
    end
  end

  // Result receiver. Ready goes high and low in random bursts, and once the
  // random part begins it is held low for a long stretch so that the block
  // fills its result slot and its sequencer and then stops taking input.
  initial begin
    int unsigned gap;
    bit          hold_done;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!steady_tail && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 6);
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(negedge clk_i);
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [DATA_W-1:0] corner_patience [4];
    logic [DATA_W-1:0] pat;
    logic [DATA_W-1:0] svc;
    efq_mode_e         op;
    int unsigned       fill_bias;
    int unsigned       roll;

    sb                = new();
    corner_patience   = '{8'd0, 8'd1, 8'd2, 8'd255};
    hold_off_req      = 1'b0;
    steady_tail       = 1'b0;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_NOP;
    in_if.patience_in = '0;
    in_if.service_in  = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening. The empty queue is probed first: a dequeue with
    // nothing to return, a tick with nothing to age and the unused mode.
    send_op(MODE_DEQ,  8'h00, 8'h00);
    send_op(MODE_TICK, 8'hff, 8'hff);
    send_op(MODE_NOP,  8'h00, 8'h00);
    // Fill the queue to the brim. The head entries carry patience zero, one,
    // two and the maximum, so the next tick removes the first two and keeps the next two.
    for (int i = 0; i < DEPTH; i++) begin
      pat = (i < 4) ? corner_patience[i] : DATA_W'($urandom_range(0, 255));
      svc = (i < 4) ? ((i % 2 == 1) ? 8'hff : 8'h00) : DATA_W'($urandom_range(0, 255));
      send_op(MODE_ENQ, pat, svc);
    end
    // A further enqueue on the full queue is refused with overflow.
    send_op(MODE_ENQ,  8'haa, 8'h55);
    send_op(MODE_TICK, 8'h00, 8'h00);
    send_op(MODE_DEQ,  8'h00, 8'h00);
    send_op(MODE_NOP,  8'hff, 8'hff);
    send_op(MODE_DEQ,  8'h00, 8'h00);

    // Random part. Every hundred operations the mix swings between draining,
    // balanced and filling, so that the queue spends time empty, half full
    // and full. Most patience values are small, so that ticks remove entries
    // often, and the rest cover the whole range.
    hold_off_req = 1'b1;
    for (int unsigned k = 0; k < RANDOM_OPS; k++) begin
      if (k % 100 == 0) begin
        fill_bias = $urandom_range(0, 2);
      end
      if (k == RANDOM_OPS - STEADY_TAIL_OPS) begin
        steady_tail = 1'b1;
      end
      roll = $urandom_range(0, 99);
      case (fill_bias)
        0: op = (roll < 20) ? MODE_ENQ : (roll < 60) ? MODE_DEQ :
                (roll < 95) ? MODE_TICK : MODE_NOP;
        1: op = (roll < 40) ? MODE_ENQ : (roll < 65) ? MODE_DEQ :
                (roll < 92) ? MODE_TICK : MODE_NOP;
        default: op = (roll < 70) ? MODE_ENQ : (roll < 80) ? MODE_DEQ :
                      (roll < 95) ? MODE_TICK : MODE_NOP;
      endcase
      pat = ($urandom_range(0, 9) < 6) ? DATA_W'($urandom_range(0, 4))
                                       : DATA_W'($urandom_range(0, 255));
      svc = DATA_W'($urandom_range(0, 255));
      send_op(op, pat, svc);
    end
    in_if.valid <= 1'b0;

    // Wait for every outstanding result, then allow time for any stray
    // transaction to show up before the verdict.
    while (sb.awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every tick
  // walking a full queue.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
